// ===== rtl/source_tokenizer_core_assert.svh =====
// Assertion macros for the source tokenizer checker.
// Each use stands on a line of its own; the property holds at every rising
// clock edge outside reset.
`ifndef SOURCE_TOKENIZER_CORE_ASSERT_SVH
`define SOURCE_TOKENIZER_CORE_ASSERT_SVH

// Plain property, sampled on clk_sig, idle while rstn_sig is low.
`define STOK_ASSERT(label, clk_sig, rstn_sig, prop) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
		else $error("stok: property violated");

// Condition in one cycle implies a consequence in the next.
`define STOK_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
		else $error("stok: next-cycle property violated");

`endif

// ===== rtl/stok_pkg.sv =====
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types, token codes and the keyword table of the source tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stok_pkg;

	// width of every position, length and line field on the result side
	localparam int FIELD_W = 16;
	localparam int KIND_W  = 5;

	// token kinds; keywords take codes 0 to 5 in table order
	localparam int               KW_COUNT  = 6;
	localparam int               KW_BYTES  = 5;
	localparam logic [KIND_W-1:0] K_EQUAL   = 5'd6;
	localparam logic [KIND_W-1:0] K_SEMI    = 5'd7;
	localparam logic [KIND_W-1:0] K_PLUS    = 5'd8;
	localparam logic [KIND_W-1:0] K_MINUS   = 5'd9;
	localparam logic [KIND_W-1:0] K_STAR    = 5'd10;
	localparam logic [KIND_W-1:0] K_SLASH   = 5'd11;
	localparam logic [KIND_W-1:0] K_LESS    = 5'd12;
	localparam logic [KIND_W-1:0] K_GREATER = 5'd13;
	localparam logic [KIND_W-1:0] K_EQEQ    = 5'd14;
	localparam logic [KIND_W-1:0] K_LPAREN  = 5'd15;
	localparam logic [KIND_W-1:0] K_RPAREN  = 5'd16;
	localparam logic [KIND_W-1:0] K_IDENT   = 5'd17;
	localparam logic [KIND_W-1:0] K_NUMBER  = 5'd18;
	localparam logic [KIND_W-1:0] K_END     = 5'd19;
	localparam logic [KIND_W-1:0] K_ERROR   = 5'd20;
	localparam logic [KIND_W-1:0] K_NEWLINE = 5'd21;

	// result queue: one byte may give two tokens
	localparam int MAX_RES = 2;
	localparam int QDEPTH  = 8;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [FIELD_W-1:0] start_pos;
		logic [FIELD_W-1:0] tok_len;
		logic [FIELD_W-1:0] line_no;
		logic               last;
	} tok_t;

	// tokens made by one byte, in delivery order; tok1 is used only when cnt is 2
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       tok0;
		tok_t       tok1;
	} scan_res_t;

	// keyword text, first byte in the low bits, padded with zero bytes
	function automatic logic [KW_BYTES*8-1:0] kw_word(input int k);
		logic [KW_BYTES*8-1:0] w;
		case (k)
			0:       w = {8'h00, 8'h00, "u", "e", "n"};
			1:       w = {8'h00, 8'h00, "i", "h", "t"};
			2:       w = {8'h00, 8'h00, "t", "e", "h"};
			3:       w = {8'h00, 8'h00, "i", "h", "k"};
			4:       w = {"g", "n", "a", "r", "t"};
			5:       w = {8'h00, 8'h00, 8'h00, "n", "i"};
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [2:0] kw_len(input int k);
		logic [2:0] n;
		case (k)
			0, 1, 2, 3: n = 3'd3;
			4:          n = 3'd5;
			5:          n = 3'd2;
			default:    n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/stok_scan.sv =====
// ----------------------------------------------------------------------------
// stok_scan
// Scanner state and the one-byte next-state logic; yields up to two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module stok_scan #(
	parameter int POSITION_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_vld,
	input  wire logic [7:0]          byte_in,
	output stok_pkg::scan_res_t      res
);
	import stok_pkg::*;

	localparam int PW   = POSITION_BITS;
	localparam int ExtW = (PW > FIELD_W) ? PW : FIELD_W;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_LESS    = 8'h3C;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_GREATER = 8'h3E;
	localparam logic [7:0] CH_UNDER   = 8'h5F;

	typedef enum logic [5:0] {
		M_IDLE    = 6'b000001,
		M_IDENT   = 6'b000010,
		M_NUMBER  = 6'b000100,
		M_EQ      = 6'b001000,
		M_SLASH   = 6'b010000,
		M_COMMENT = 6'b100000
	} mode_t;

	mode_t                      mode_q, mode_d;
	logic [PW-1:0]              pos_q, pos_d;
	logic [PW-1:0]              begin_q, begin_d;
	logic [PW-1:0]              run_q, run_d;
	logic [PW-1:0]              line_q, line_d;
	logic [KW_BYTES-1:0][7:0]   prefix_q, prefix_d;

	logic        is_alpha, is_digit, is_word;
	logic        consumed, ended, have_a, have_b;
	logic [KIND_W-1:0] word_kind;
	tok_t        tok_a, tok_b;

	function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
		return (v == {PW{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic [FIELD_W-1:0] to_field(input logic [PW-1:0] v);
		logic [ExtW-1:0] e;
		e = ExtW'(v);
		return e[FIELD_W-1:0];
	endfunction

	assign is_alpha = ((byte_in >= "a") && (byte_in <= "z")) ||
	                  ((byte_in >= "A") && (byte_in <= "Z"));
	assign is_digit = (byte_in >= "0") && (byte_in <= "9");
	assign is_word  = is_alpha || is_digit || (byte_in == CH_UNDER);

	// Prefix bytes past the run length stay zero, so a full-width compare
	// with the zero-padded keyword equals a compare over the keyword length.
	always_comb begin
		word_kind = K_IDENT;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if ((run_q == PW'(kw_len(k))) && (prefix_q == kw_word(k))) begin
				word_kind = KIND_W'(k);
			end
		end
	end

	always_comb begin
		mode_d   = mode_q;
		begin_d  = begin_q;
		run_d    = run_q;
		line_d   = line_q;
		prefix_d = prefix_q;
		pos_d    = sat_inc(pos_q);
		consumed = 1'b0;
		ended    = 1'b0;
		have_a   = 1'b0;
		have_b   = 1'b0;
		tok_a    = '0;
		tok_b    = '0;

		// close or extend the pending token
		case (mode_q)
			M_IDENT: begin
				if (is_word) begin
					if (run_q < PW'(KW_BYTES)) begin
						prefix_d[run_q[2:0]] = byte_in;
					end
					run_d    = sat_inc(run_q);
					consumed = 1'b1;
				end else begin
					have_a          = 1'b1;
					tok_a.kind      = word_kind;
					tok_a.start_pos = to_field(begin_q);
					tok_a.tok_len   = to_field(run_q);
					mode_d          = M_IDLE;
				end
			end
			M_NUMBER: begin
				if (is_digit) begin
					run_d    = sat_inc(run_q);
					consumed = 1'b1;
				end else begin
					have_a          = 1'b1;
					tok_a.kind      = K_NUMBER;
					tok_a.start_pos = to_field(begin_q);
					tok_a.tok_len   = to_field(run_q);
					mode_d          = M_IDLE;
				end
			end
			M_EQ: begin
				mode_d          = M_IDLE;
				have_a          = 1'b1;
				tok_a.start_pos = to_field(begin_q);
				if (byte_in == CH_EQUAL) begin
					tok_a.kind    = K_EQEQ;
					tok_a.tok_len = FIELD_W'(2);
					consumed      = 1'b1;
				end else begin
					tok_a.kind    = K_EQUAL;
					tok_a.tok_len = FIELD_W'(1);
				end
			end
			M_SLASH: begin
				if (byte_in == CH_SLASH) begin
					mode_d   = M_COMMENT;
					consumed = 1'b1;
				end else begin
					have_a          = 1'b1;
					tok_a.kind      = K_SLASH;
					tok_a.start_pos = to_field(begin_q);
					tok_a.tok_len   = FIELD_W'(1);
					mode_d          = M_IDLE;
				end
			end
			M_COMMENT: begin
				if ((byte_in == CH_LF) || (byte_in == CH_NUL)) begin
					mode_d = M_IDLE;
				end else begin
					consumed = 1'b1;
				end
			end
			default: begin
				mode_d = M_IDLE;
			end
		endcase
		tok_a.line_no = to_field(line_q);

		// start a new token from this byte
		tok_b.start_pos = to_field(pos_q);
		tok_b.tok_len   = FIELD_W'(1);
		if (!consumed) begin
			case (byte_in)
				CH_NUL: begin
					have_b        = 1'b1;
					tok_b.kind    = K_END;
					tok_b.tok_len = '0;
					ended         = 1'b1;
				end
				CH_SPACE, CH_TAB, CH_CR: begin
				end
				CH_HASH: mode_d = M_COMMENT;
				CH_SLASH: begin
					mode_d  = M_SLASH;
					begin_d = pos_q;
				end
				CH_EQUAL: begin
					mode_d  = M_EQ;
					begin_d = pos_q;
				end
				CH_LF: begin
					line_d     = sat_inc(line_q);
					have_b     = 1'b1;
					tok_b.kind = K_NEWLINE;
				end
				CH_SEMI: begin
					have_b     = 1'b1;
					tok_b.kind = K_SEMI;
				end
				CH_PLUS: begin
					have_b     = 1'b1;
					tok_b.kind = K_PLUS;
				end
				CH_MINUS: begin
					have_b     = 1'b1;
					tok_b.kind = K_MINUS;
				end
				CH_STAR: begin
					have_b     = 1'b1;
					tok_b.kind = K_STAR;
				end
				CH_LESS: begin
					have_b     = 1'b1;
					tok_b.kind = K_LESS;
				end
				CH_GREATER: begin
					have_b     = 1'b1;
					tok_b.kind = K_GREATER;
				end
				CH_LPAREN: begin
					have_b     = 1'b1;
					tok_b.kind = K_LPAREN;
				end
				CH_RPAREN: begin
					have_b     = 1'b1;
					tok_b.kind = K_RPAREN;
				end
				default: begin
					if (is_alpha) begin
						mode_d      = M_IDENT;
						begin_d     = pos_q;
						run_d       = PW'(1);
						prefix_d    = '0;
						prefix_d[0] = byte_in;
					end else if (is_digit) begin
						mode_d  = M_NUMBER;
						begin_d = pos_q;
						run_d   = PW'(1);
					end else begin
						have_b     = 1'b1;
						tok_b.kind = K_ERROR;
					end
				end
			endcase
		end
		tok_b.line_no = to_field(line_d);
		tok_b.last    = 1'b1;
		tok_a.last    = !have_b;

		res.cnt  = {1'b0, have_a} + {1'b0, have_b};
		res.tok0 = have_a ? tok_a : tok_b;
		res.tok1 = tok_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pos_q    <= '0;
			begin_q  <= '0;
			run_q    <= '0;
			line_q   <= PW'(1);
			prefix_q <= '0;
		end else if (byte_vld) begin
			if (ended) begin
				mode_q   <= M_IDLE;
				pos_q    <= '0;
				begin_q  <= '0;
				run_q    <= '0;
				line_q   <= PW'(1);
				prefix_q <= '0;
			end else begin
				mode_q   <= mode_d;
				pos_q    <= pos_d;
				begin_q  <= begin_d;
				run_q    <= run_d;
				line_q   <= line_d;
				prefix_q <= prefix_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/stok_queue.sv =====
// ----------------------------------------------------------------------------
// stok_queue
// Token queue: takes up to two tokens a cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module stok_queue (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire stok_pkg::scan_res_t        res,
	output logic                            out_vld,
	input  wire logic                       out_rdy,
	output stok_pkg::tok_t                  out_tok,
	output logic [stok_pkg::QCNT_W-1:0]     level
);
	import stok_pkg::*;

	tok_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] level_q;
	logic [1:0]        n_in;
	logic              pop;

	assign n_in    = push ? res.cnt : 2'd0;
	assign pop     = out_vld && out_rdy;
	assign out_vld = (level_q != '0);
	assign out_tok = mem_q[rd_ptr_q];
	assign level   = level_q;

	always_ff @(posedge clk) begin
		if (n_in != 2'd0) begin
			mem_q[wr_ptr_q] <= res.tok0;
		end
		if (n_in == 2'd2) begin
			mem_q[wr_ptr_q + 1'b1] <= res.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_in);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			level_q <= level_q + QCNT_W'(n_in) - QCNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/source_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// source_tokenizer_core
// Streaming lexical scanner: source bytes in, tokens out.
// ----------------------------------------------------------------------------
//
//   channel   direction  width  carries
//   s_axis    in         8      tdata: ch (source byte, zero ends the source)
//   m_axis    out        56+1   tdata: kind, start_pos, tok_len, line_no;
//                               tlast: last token made by its byte
//
// One byte is taken per cycle while the token queue has room; the scan logic
// sits between the byte register and the queue, so a byte's tokens pass
// through the byte register and are written into the queue before they are
// shown on m_axis. A byte yields up to two tokens and m_axis moves one per
// cycle while m_axis_tready is high, so bytes that close one token and make
// another need two transfers on m_axis. arst_n clears the scanner to
// its start state (position 0, line 1) and empties the queue; a zero byte
// does the same to the scanner after its end token. A stalled m_axis holds
// tokens in the eight-entry queue and drops s_axis tready once it cannot
// take two more tokens besides the byte already in the register.
// ----------------------------------------------------------------------------
`default_nettype none

module source_tokenizer_core #(
	parameter int POSITION_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata,   // [4:0] kind, [20:5] start_pos,
	                                         // [36:21] tok_len, [52:37] line_no,
	                                         // [55:53] zero
	output logic             m_axis_tlast    // last token of its byte
);
	import stok_pkg::*;

	// queue slots that a byte may need, and the fill level at which to hold off
	localparam logic [QCNT_W:0] PER_BYTE   = (QCNT_W + 1)'(MAX_RES);
	localparam logic [QCNT_W:0] TAKE_LIMIT = (QCNT_W + 1)'(QDEPTH - MAX_RES);

	logic              vld_s1;
	logic [7:0]        ch_s1;
	logic              in_xfer;
	logic [QCNT_W-1:0] level;
	logic [QCNT_W:0]   fill_ahead;
	scan_res_t         res;
	tok_t              out_tok;

	// count the register's byte as two tokens already on their way
	assign fill_ahead    = {1'b0, level} + (vld_s1 ? PER_BYTE : '0);
	assign s_axis_tready = (fill_ahead <= TAKE_LIMIT);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// byte register: advance on every transfer, drop the valid bit otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ch_s1 <= s_axis_tdata;
		end
	end

	stok_scan #(
		.POSITION_BITS(POSITION_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_vld (vld_s1),
		.byte_in  (ch_s1),
		.res      (res)
	);

	stok_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (vld_s1),
		.res     (res),
		.out_vld (m_axis_tvalid),
		.out_rdy (m_axis_tready),
		.out_tok (out_tok),
		.level   (level)
	);

	// pack the token fields from the lowest bit up
	assign m_axis_tdata = {3'b000, out_tok.line_no, out_tok.tok_len,
	                       out_tok.start_pos, out_tok.kind};
	assign m_axis_tlast = out_tok.last;

endmodule

`default_nettype wire

// ===== rtl/stok_checker.sv =====
// ----------------------------------------------------------------------------
// stok_checker
// Port-level checks on the token stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "source_tokenizer_core_assert.svh"

module stok_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [7:0]  s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [55:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);
	import stok_pkg::*;

	logic [KIND_W-1:0]  kind;
	logic [FIELD_W-1:0] tok_len;
	logic               in_xfer;

	assign kind    = m_axis_tdata[4:0];
	assign tok_len = m_axis_tdata[36:21];
	assign in_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tdata != 8'h00);

	// a stalled token holds until its transfer
	`STOK_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

	// end of input is always the final token of its byte and has no length
	`STOK_ASSERT(a_end_shape, clk, arst_n, (m_axis_tvalid && (kind == K_END)) |-> (m_axis_tlast && (tok_len == '0)))

	// error, newline, semicolon and left parenthesis tokens span one byte
	`STOK_ASSERT(a_single_len, clk, arst_n, (m_axis_tvalid && ((kind == K_ERROR) || (kind == K_NEWLINE) || (kind == K_SEMI) || (kind == K_LPAREN))) |-> (tok_len == FIELD_W'(1)))

	// no token code beyond newline ever leaves the block
	`STOK_ASSERT(a_kind_range, clk, arst_n, (m_axis_tvalid || in_xfer) |-> (!m_axis_tvalid || (kind <= K_NEWLINE)))

endmodule

bind source_tokenizer_core stok_checker u_stok_checker (.*);

`default_nettype wire

// ===== bench/source_tokenizer_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_tokenizer_core_tb
// Self-checking bench for the streaming tokenizer. Source bytes go in on
// s_axis and the tokens that come out on m_axis are compared field by field
// with a bit-accurate scanner model. Stimulus is a short hand-written
// fragment, then random token-shaped text under three pacing regimes, and
// last a source that ends with a number pending.
// ----------------------------------------------------------------------------

import stok_pkg::*;

module source_tokenizer_core_tb;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 12;
	localparam int STALL_LIMIT  = 2000;   // cycles without any transfer
	localparam int DRAIN_CYCLES = 24;
	localparam int PHASE_BYTES  = 520;    // least bytes per pacing regime

	// non-printing source bytes; printable ones are written as literals
	localparam byte unsigned CH_NUL = 8'h00;
	localparam byte unsigned CH_TAB = 8'h09;
	localparam byte unsigned CH_LF  = 8'h0A;
	localparam byte unsigned CH_CR  = 8'h0D;

	typedef enum logic [2:0] {
		SCAN_IDLE, SCAN_WORD, SCAN_DIGITS, SCAN_EQ, SCAN_SLASH, SCAN_COMMENT
	} scan_mode_t;

	// keyword kinds, in the order of their token codes
	typedef enum logic [KIND_W-1:0] {
		KW_NEU, KW_THI, KW_HET, KW_KHI, KW_TRANG, KW_IN
	} keyword_t;

	// Scanner model plus the queue of tokens still owed by the block
	class token_board;
		localparam int MAX_REPORTS = 40;

		scan_mode_t         mode;
		logic [FIELD_W-1:0] byte_pos;
		logic [FIELD_W-1:0] tok_begin;
		logic [FIELD_W-1:0] run_len;
		logic [FIELD_W-1:0] line_count;
		byte unsigned       prefix [KW_BYTES];
		tok_t               owed_tokens [$];
		int                 n_errors;
		int                 n_checked;
		int                 n_reports;

		function new();
			clear_scanner();
			n_errors  = 0;
			n_checked = 0;
			n_reports = 0;
		endfunction

		static function string keyword_text(keyword_t kw);
			case (kw)
				KW_NEU:   return "neu";
				KW_THI:   return "thi";
				KW_HET:   return "het";
				KW_KHI:   return "khi";
				KW_TRANG: return "trang";
				default:  return "in";
			endcase
		endfunction

		function void clear_scanner();
			mode       = SCAN_IDLE;
			byte_pos   = '0;
			tok_begin  = '0;
			run_len    = '0;
			line_count = 1;
			foreach (prefix[i]) prefix[i] = 8'h00;
		endfunction

		// hold at all ones
		static function logic [FIELD_W-1:0] bump(logic [FIELD_W-1:0] v);
			return (&v) ? v : v + 1'b1;
		endfunction

		static function bit is_alpha(byte unsigned c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		static function bit is_digit(byte unsigned c);
			return c >= "0" && c <= "9";
		endfunction

		function tok_t make_tok(logic [KIND_W-1:0] kind, logic [FIELD_W-1:0] start,
				logic [FIELD_W-1:0] len);
			tok_t t;
			t.kind      = kind;
			t.start_pos = start;
			t.tok_len   = len;
			t.line_no   = line_count;
			t.last      = 1'b0;
			return t;
		endfunction

		// a keyword needs the exact length and the stored prefix to match
		function logic [KIND_W-1:0] word_kind();
			string    text;
			keyword_t kw;
			bit       hit;
			for (int k = 0; k < KW_COUNT; k++) begin
				kw   = keyword_t'(k);
				text = keyword_text(kw);
				if (run_len == text.len()) begin
					hit = 1'b1;
					for (int i = 0; i < text.len(); i++)
						if (prefix[i] != text[i]) hit = 1'b0;
					if (hit) return kw;
				end
			end
			return K_IDENT;
		endfunction

		// advance the model by one accepted byte and queue the tokens it makes
		function void note_byte(byte unsigned c);
			tok_t               made [$];
			tok_t               t;
			bit                 consumed;
			bit                 ended;
			logic [FIELD_W-1:0] p;
			consumed = 1'b0;
			ended    = 1'b0;
			p        = byte_pos;

			// first let the byte close or extend whatever is pending
			case (mode)
				SCAN_WORD: begin
					if (is_alpha(c) || is_digit(c) || c == "_") begin
						if (run_len < KW_BYTES) prefix[run_len] = c;
						run_len  = bump(run_len);
						consumed = 1'b1;
					end else begin
						made.push_back(make_tok(word_kind(), tok_begin, run_len));
						mode = SCAN_IDLE;
					end
				end
				SCAN_DIGITS: begin
					if (is_digit(c)) begin
						run_len  = bump(run_len);
						consumed = 1'b1;
					end else begin
						made.push_back(make_tok(K_NUMBER, tok_begin, run_len));
						mode = SCAN_IDLE;
					end
				end
				SCAN_EQ: begin
					mode = SCAN_IDLE;
					if (c == "=") begin
						made.push_back(make_tok(K_EQEQ, tok_begin, 2));
						consumed = 1'b1;
					end else begin
						made.push_back(make_tok(K_EQUAL, tok_begin, 1));
					end
				end
				SCAN_SLASH: begin
					if (c == "/") begin
						mode     = SCAN_COMMENT;
						consumed = 1'b1;
					end else begin
						made.push_back(make_tok(K_SLASH, tok_begin, 1));
						mode = SCAN_IDLE;
					end
				end
				SCAN_COMMENT: begin
					if (c == CH_LF || c == CH_NUL) mode = SCAN_IDLE;
					else consumed = 1'b1;
				end
				default: ;
			endcase

			// then let it start something new
			if (!consumed) begin
				case (c)
					CH_NUL: begin
						made.push_back(make_tok(K_END, p, 0));
						ended = 1'b1;
					end
					" ", CH_TAB, CH_CR: ;
					"#": mode = SCAN_COMMENT;
					"/": begin
						mode      = SCAN_SLASH;
						tok_begin = p;
					end
					"=": begin
						mode      = SCAN_EQ;
						tok_begin = p;
					end
					CH_LF: begin
						line_count = bump(line_count);
						made.push_back(make_tok(K_NEWLINE, p, 1));
					end
					";": made.push_back(make_tok(K_SEMI, p, 1));
					"+": made.push_back(make_tok(K_PLUS, p, 1));
					"-": made.push_back(make_tok(K_MINUS, p, 1));
					"*": made.push_back(make_tok(K_STAR, p, 1));
					"<": made.push_back(make_tok(K_LESS, p, 1));
					">": made.push_back(make_tok(K_GREATER, p, 1));
					"(": made.push_back(make_tok(K_LPAREN, p, 1));
					")": made.push_back(make_tok(K_RPAREN, p, 1));
					default: begin
						if (is_alpha(c)) begin
							mode      = SCAN_WORD;
							tok_begin = p;
							run_len   = 1;
							foreach (prefix[i]) prefix[i] = 8'h00;
							prefix[0] = c;
						end else if (is_digit(c)) begin
							mode      = SCAN_DIGITS;
							tok_begin = p;
							run_len   = 1;
						end else begin
							made.push_back(make_tok(K_ERROR, p, 1));
						end
					end
				endcase
			end

			byte_pos = bump(byte_pos);
			for (int i = 0; i < made.size(); i++) begin
				t      = made[i];
				t.last = (i == made.size() - 1);
				owed_tokens.push_back(t);
			end
			if (ended) clear_scanner();
		endfunction

		function void report_field(string name, logic [FIELD_W-1:0] want,
				logic [FIELD_W-1:0] got);
			if (got !== want) begin
				n_errors++;
				if (n_reports < MAX_REPORTS) begin
					n_reports++;
					$display("%0t: token %0d %s mismatch: expected %0d, actual %0d",
						$time, n_checked, name, want, got);
				end
			end
		endfunction

		// compare one delivered token with the oldest one owed
		function void check_token(logic [55:0] data, logic tlast);
			tok_t want;
			tok_t got;
			got.kind      = data[4:0];
			got.start_pos = data[20:5];
			got.tok_len   = data[36:21];
			got.line_no   = data[52:37];
			got.last      = tlast;
			n_checked++;
			if (owed_tokens.size() == 0) begin
				n_errors++;
				if (n_reports < MAX_REPORTS) begin
					n_reports++;
					$display("%0t: token %0d unexpected: expected none, actual kind %0d start %0d len %0d line %0d last %0d",
						$time, n_checked, got.kind, got.start_pos, got.tok_len,
						got.line_no, got.last);
				end
				return;
			end
			want = owed_tokens.pop_front();
			report_field("kind", want.kind, got.kind);
			report_field("start_pos", want.start_pos, got.start_pos);
			report_field("tok_len", want.tok_len, got.tok_len);
			report_field("line_no", want.line_no, got.line_no);
			report_field("last", want.last, got.last);
		endfunction
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        m_axis_tready = 1'b0;
	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic [55:0] m_axis_tdata;
	logic        m_axis_tlast;

	token_board   board = new();
	byte unsigned source_bytes [$];
	int           tx_idle_pct  = 29;
	int           rx_idle_pct  = 51;
	int           stall_cycles = 0;
	longint       bytes_sent   = 0;

	source_tokenizer_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #HALF_PERIOD clk = ~clk;

	// Receiver: stall at random for the share set by the current phase
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
	end

	// Monitor both channels; the byte is noted before any token is checked,
	// and the watchdog trips when neither side has moved for too long
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) board.note_byte(s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready) board.check_token(m_axis_tdata, m_axis_tlast);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d tokens still owed",
				$time, stall_cycles, board.owed_tokens.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// Offer one byte, idling first at random, and hold it until the transfer
	task automatic send_byte(input byte unsigned b);
		while ($urandom_range(99, 0) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	task automatic send_queued();
		while (source_bytes.size() != 0) send_byte(source_bytes.pop_front());
	endtask

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) source_bytes.push_back(s[i]);
	endfunction

	function automatic byte unsigned rand_letter();
		int r;
		r = $urandom_range(51, 0);
		return (r < 26) ? byte'("a" + r) : byte'("A" + r - 26);
	endfunction

	function automatic byte unsigned rand_word_char();
		int r;
		r = $urandom_range(9, 0);
		if (r < 6) return rand_letter();
		if (r < 9) return byte'("0" + $urandom_range(9, 0));
		return "_";
	endfunction

	// comment text: anything but a line feed, closed by a line feed or now
	// and then by the end of the source
	function automatic void add_comment_body();
		byte unsigned b;
		repeat ($urandom_range(6, 0)) begin
			b = byte'($urandom_range(255, 1));
			source_bytes.push_back((b == CH_LF) ? byte'("x") : b);
		end
		source_bytes.push_back(($urandom_range(7, 0) == 0) ? CH_NUL : CH_LF);
	endfunction

	// Append one random lexeme; most are well-formed tokens written back to
	// back so that every lookahead case gets hit, a few are raw noise
	function automatic void add_lexeme();
		int    r;
		string text;
		string punct;
		r     = $urandom_range(99, 0);
		punct = ";+-*<>()";
		if (r < 12) begin
			add_text(token_board::keyword_text(keyword_t'($urandom_range(KW_COUNT - 1, 0))));
		end else if (r < 18) begin
			// near misses: one byte too many, one too few, or a capital
			text = token_board::keyword_text(keyword_t'($urandom_range(KW_COUNT - 1, 0)));
			case ($urandom_range(2, 0))
				0: begin
					add_text(text);
					source_bytes.push_back(rand_word_char());
				end
				1: add_text(text.substr(0, text.len() - 2));
				default: begin
					source_bytes.push_back(text[0] - 8'h20);
					add_text(text.substr(1, text.len() - 1));
				end
			endcase
		end else if (r < 32) begin
			source_bytes.push_back(rand_letter());
			repeat ($urandom_range(7, 0)) source_bytes.push_back(rand_word_char());
		end else if (r < 42) begin
			repeat ($urandom_range(6, 1))
				source_bytes.push_back(byte'("0" + $urandom_range(9, 0)));
		end else if (r < 54) begin
			source_bytes.push_back(punct[$urandom_range(7, 0)]);
		end else if (r < 59) begin
			add_text("=");
		end else if (r < 63) begin
			add_text("==");
		end else if (r < 67) begin
			add_text("/");
		end else if (r < 71) begin
			add_text("//");
			add_comment_body();
		end else if (r < 75) begin
			add_text("#");
			add_comment_body();
		end else if (r < 90) begin
			repeat ($urandom_range(3, 1)) begin
				case ($urandom_range(2, 0))
					0:       source_bytes.push_back(" ");
					1:       source_bytes.push_back(CH_TAB);
					default: source_bytes.push_back(CH_CR);
				endcase
			end
		end else if (r < 95) begin
			source_bytes.push_back(CH_LF);
		end else if (r < 98) begin
			source_bytes.push_back(byte'($urandom_range(255, 1)));
		end else begin
			source_bytes.push_back(CH_NUL);
		end
	endfunction

	task automatic send_random_source();
		while (source_bytes.size() < PHASE_BYTES) add_lexeme();
		send_queued();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hand-written fragment: a keyword, every punctuator, '=' against '==',
		// a lone slash, a slash comment, an unknown byte, '=' flushed by a tab
		// and a hash comment cut short by the end of the source
		add_text("in(x1=9)==;+-*<>/a//");
		source_bytes.push_back(8'hFF);
		source_bytes.push_back(CH_LF);
		add_text("@=");
		source_bytes.push_back(CH_TAB);
		add_text("#");
		source_bytes.push_back(8'h80);
		source_bytes.push_back(CH_NUL);
		send_queued();

		// Random text under three pacing regimes
		send_random_source();
		tx_idle_pct = 51;
		rx_idle_pct = 29;
		send_random_source();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random_source();

		// Close whatever is pending and end the source with a number pending
		add_text(" ;7");
		source_bytes.push_back(CH_NUL);
		send_queued();
		s_axis_tvalid <= 1'b0;

		// Drain what is owed, then give stray tokens a chance to show up
		while (board.owed_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d source bytes and %0d tokens, %0d mismatches found.",
			bytes_sent, board.n_checked, board.n_errors);
		$display("Pacing: both sides stalling in turn, then full rate on both sides.");
		if (board.n_errors == 0 && board.owed_tokens.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
